>>> src/frps_pkg.sv
// Package for the filtered record page search block.
// Holds the shared types, codes and default sizes. Depends on nothing.
package frps_pkg;

    localparam int SLOTS_DEF = 256;
    localparam int PAGE_DEF  = 8;

    localparam int CLASS_W  = 3;
    localparam int TIME_W   = 32;
    localparam int MASK_W   = 8;
    localparam int PNUM_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = CLASS_W + TIME_W;

    localparam logic [PNUM_W-1:0] PAGE_MAX = 8'hFF;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd3;

    localparam logic [1:0] CFG_CLASS_MASK   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_START = 2'd1;
    localparam logic [1:0] CFG_WINDOW_END   = 2'd2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_DOWN   = 2'd2,
        MODE_UP     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Filter settings handed to the match unit.
    typedef struct packed {
        logic [MASK_W-1:0] class_mask;
        logic [TIME_W-1:0] window_start;
        logic [TIME_W-1:0] window_end;
    } t_filter;

endpackage

>>> src/frps_store.sv
// Record memory of the filtered record page search block: class and timestamp.
// One write port, one read port with a registered read. Uses frps_pkg.
module frps_store
    import frps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [IW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [SLOTS];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Output holds its value while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/frps_match.sv
// Match test for one record read from the store: class mask and time window.
// Uses the filter struct of frps_pkg.
module frps_match
    import frps_pkg::*;
(
    input  logic               i_occupied,
    input  logic [ENTRY_W-1:0] i_entry,
    input  t_filter            i_filter,
    output logic               o_hit
);

    logic [CLASS_W-1:0] w_class;
    logic [TIME_W-1:0]  w_time;

    assign w_class = i_entry[ENTRY_W-1:TIME_W];
    assign w_time  = i_entry[TIME_W-1:0];

    // An inverted window fails at least one of the two compares for every timestamp.
    assign o_hit = i_occupied
                 && i_filter.class_mask[w_class]
                 && (i_filter.window_start <= w_time)
                 && (w_time <= i_filter.window_end);

endmodule

>>> src/filtered_record_page_search.sv
// Top level of the filtered record page search block: control and registers.
// Instantiates frps_store and frps_match; uses frps_pkg.
//
// Channel   Dir  Handshake                        Content
// s_axis    in   s_axis_tvalid / s_axis_tready    request item: mode, record
// m_axis    out  m_axis_tvalid / m_axis_tready    result item: index, page, status
// cfg       in   i_cfg_valid / o_cfg_ready        register write: index, data
//
// An insert or a refused page move is answered from S_IDLE. A page request is
// taken in S_IDLE; S_SCAN issues one store read per slot over a full circle and
// compares each record once its read returns; S_FINISH then closes. The
// scan ends early once PAGE matches are found. A match that finds the held result
// still waiting on a stalled output holds the scan on the current slot.
// Reset is synchronous and active low. Slots fill from index 0 upward and are
// never freed, so a fill count marks them and the store needs no clearing pass.
module filtered_record_page_search
    import frps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int PAGE  = PAGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request item. tdata from bit 0: record_class[2:0], record_time[34:3], zero fill.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // tuser from bit 0: mode[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Result item. tdata from bit 0: slot_index[7:0], page_number[15:8].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser from bit 0: status[1:0].
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int FW = $clog2(PAGE + 1);

    // Control registers.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_issued, n_issued;
    logic               r_dv, n_dv;
    logic [FW-1:0]      r_found, n_found;
    logic               r_pend_v, n_pend_v;
    logic               r_fwd, n_fwd;
    logic [PNUM_W-1:0]  r_page, n_page;
    logic               r_lpf, n_lpf;
    logic               r_out_v, n_out_v;
    t_filter            r_filter, n_filter;

    // Payload registers.
    logic [IW-1:0]       r_didx, n_didx;
    logic [IW-1:0]       r_pend_idx, n_pend_idx;
    logic [IW-1:0]       r_out_idx, n_out_idx;
    logic [STATUS_W-1:0] r_out_st, n_out_st;
    logic [PNUM_W-1:0]   r_out_page, n_out_page;
    logic                r_out_last, n_out_last;

    logic               w_we;
    logic               w_re;
    logic [ENTRY_W-1:0] w_rdata;
    logic               w_hit;
    logic               w_occupied;
    logic               w_out_free;
    logic               w_stall;
    logic               w_stop;
    logic               w_push;
    logic [IW-1:0]      w_push_idx;
    logic [STATUS_W-1:0] w_push_st;
    logic               w_push_last;
    logic [IW+7:0]      w_idx_ext;
    t_mode              w_mode;

    frps_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({s_axis_tdata[2:0], s_axis_tdata[34:3]}),
        .i_re    (w_re),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // Slots below the fill count are occupied.
    assign w_occupied = (CW'(r_didx) < r_count);

    frps_match u_match (
        .i_occupied (w_occupied),
        .i_entry    (w_rdata),
        .i_filter   (r_filter),
        .o_hit      (w_hit)
    );

    function automatic logic [IW-1:0] step_pos(input logic [IW-1:0] idx, input logic fwd);
        logic [IW-1:0] res;
        if (fwd) begin
            res = (idx == IW'(SLOTS - 1)) ? '0 : idx + 1'b1;
        end else begin
            res = (idx == '0) ? IW'(SLOTS - 1) : idx - 1'b1;
        end
        return res;
    endfunction

    assign w_mode        = t_mode'(s_axis_tuser);
    assign w_out_free    = !r_out_v || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_issued   = r_issued;
        n_dv       = r_dv;
        n_found    = r_found;
        n_pend_v   = r_pend_v;
        n_fwd      = r_fwd;
        n_page     = r_page;
        n_lpf      = r_lpf;
        n_filter   = r_filter;
        n_didx     = r_didx;
        n_pend_idx = r_pend_idx;
        n_out_v    = r_out_v;
        n_out_idx  = r_out_idx;
        n_out_st   = r_out_st;
        n_out_page = r_out_page;
        n_out_last = r_out_last;

        w_we        = 1'b0;
        w_re        = 1'b0;
        w_stall     = 1'b0;
        w_stop      = 1'b0;
        w_push      = 1'b0;
        w_push_idx  = '0;
        w_push_st   = ST_OK;
        w_push_last = 1'b1;

        if (r_out_v && m_axis_tready) begin
            n_out_v = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLASS_MASK:   n_filter.class_mask   = i_cfg_data[MASK_W-1:0];
                CFG_WINDOW_START: n_filter.window_start = i_cfg_data;
                CFG_WINDOW_END:   n_filter.window_end   = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (w_mode)
                        MODE_INSERT: begin
                            if (r_count < CW'(SLOTS)) begin
                                w_we       = 1'b1;
                                w_push     = 1'b1;
                                w_push_idx = r_count[IW-1:0];
                                n_count    = r_count + 1'b1;
                            end else begin
                                w_push    = 1'b1;
                                w_push_st = ST_FULL;
                            end
                        end
                        MODE_FIRST: begin
                            n_pos   = '0;
                            n_page  = PNUM_W'(1);
                            n_fwd   = 1'b1;
                            n_state = S_SCAN;
                        end
                        MODE_DOWN: begin
                            if (!r_lpf) begin
                                w_push    = 1'b1;
                                w_push_st = ST_REFUSED;
                            end else begin
                                if (r_page != PAGE_MAX) begin
                                    n_page = r_page + 1'b1;
                                end
                                n_fwd   = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        MODE_UP: begin
                            if (r_page <= PNUM_W'(1)) begin
                                w_push    = 1'b1;
                                w_push_st = ST_REFUSED;
                            end else begin
                                n_page  = r_page - 1'b1;
                                n_fwd   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                    if (n_state == S_SCAN) begin
                        n_issued = '0;
                        n_dv     = 1'b0;
                        n_found  = '0;
                        n_pend_v = 1'b0;
                    end
                end
            end

            S_SCAN: begin
                // A new match must move the held one out first; wait for room.
                w_stall = r_dv && w_hit && r_pend_v && !w_out_free;
                if (!w_stall) begin
                    if (r_dv && w_hit) begin
                        if (r_pend_v) begin
                            w_push      = 1'b1;
                            w_push_idx  = r_pend_idx;
                            w_push_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_didx;
                        n_found    = r_found + 1'b1;
                        if (r_found == FW'(PAGE - 1)) begin
                            // Page complete: resume after this slot next time.
                            w_stop  = 1'b1;
                            n_pos   = step_pos(r_didx, r_fwd);
                            n_dv    = 1'b0;
                            n_state = S_FINISH;
                        end
                    end
                    if (!w_stop) begin
                        if (r_issued < CW'(SLOTS)) begin
                            w_re     = 1'b1;
                            n_didx   = r_pos;
                            n_dv     = 1'b1;
                            n_pos    = step_pos(r_pos, r_fwd);
                            n_issued = r_issued + 1'b1;
                        end else begin
                            // Full circle done; the position is back at its start.
                            n_dv    = 1'b0;
                            n_state = S_FINISH;
                        end
                    end
                end
            end

            S_FINISH: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    if (r_pend_v) begin
                        w_push_idx = r_pend_idx;
                    end else begin
                        w_push_st = ST_NO_MATCH;
                    end
                    n_lpf   = (r_found == FW'(PAGE));
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (w_push) begin
            n_out_v    = 1'b1;
            n_out_idx  = w_push_idx;
            n_out_st   = w_push_st;
            n_out_page = n_page;
            n_out_last = w_push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pos    <= '0;
            r_issued <= '0;
            r_dv     <= 1'b0;
            r_found  <= '0;
            r_pend_v <= 1'b0;
            r_fwd    <= 1'b1;
            r_page   <= '0;
            r_lpf    <= 1'b0;
            r_out_v  <= 1'b0;
            r_filter <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_issued <= n_issued;
            r_dv     <= n_dv;
            r_found  <= n_found;
            r_pend_v <= n_pend_v;
            r_fwd    <= n_fwd;
            r_page   <= n_page;
            r_lpf    <= n_lpf;
            r_out_v  <= n_out_v;
            r_filter <= n_filter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx     <= n_didx;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_st   <= n_out_st;
        r_out_page <= n_out_page;
        r_out_last <= n_out_last;
    end

    // The slot index carries the low eight bits of the slot number.
    assign w_idx_ext     = {8'b0, r_out_idx};
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_page, w_idx_ext[7:0]};
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tlast  = r_out_last;

endmodule
